// ----- sv/crb_pkg.sv -----
// Shared types and constants for the connection retry/backoff supervisor.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package crb_pkg;

    localparam int CNT_W      = 32;
    localparam int MODE_W     = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FLOOR_MS       = 1000;
    localparam int DEFAULT_MAX_MS = 8000;
    localparam int PROBE_RESET_MS = 5000;

    localparam logic [CNT_W-1:0] U32_ALL = '1;

    typedef enum logic [2:0] {
        ST_VOID       = 3'd0,
        ST_BACKOFF    = 3'd1,
        ST_CONNECTING = 3'd2,
        ST_ACTIVE     = 3'd3,
        ST_IDLE       = 3'd4,
        ST_RECONNECT  = 3'd5,
        ST_LISTENING  = 3'd6
    } state_t;

    typedef enum logic [1:0] {
        AC_NONE       = 2'd0,
        AC_CONNECT    = 2'd1,
        AC_DISCONNECT = 2'd2,
        AC_PROBE      = 2'd3
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MD_POLL       = 4'd0,
        MD_ENABLE     = 4'd1,
        MD_DISABLE    = 4'd2,
        MD_FORCE      = 4'd3,
        MD_DROPPED    = 4'd4,
        MD_CONNECTING = 4'd5,
        MD_LISTENING  = 4'd6,
        MD_LISTEN_ERR = 4'd7,
        MD_CONNECTED  = 4'd8,
        MD_FAILED     = 4'd9,
        MD_ACTIVITY   = 4'd10
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_BACKOFF = 3'd0,
        CFG_MAX_BACKOFF = 3'd1,
        CFG_PROBE       = 3'd2,
        CFG_PASSIVE     = 3'd3,
        CFG_TRY_LIMIT   = 3'd4,
        CFG_FREE_TRIES  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] attempts;
        logic [CNT_W-1:0] successes;
        logic [CNT_W-1:0] change_seq;
    } cnt_t;

    typedef struct packed {
        state_t           state;
        logic [CNT_W-1:0] tries_left;
        cnt_t             cnt;
    } status_t;

    function automatic logic is_linked(state_t s);
        return (s == ST_ACTIVE) || (s == ST_IDLE);
    endfunction

endpackage

`default_nettype wire

// ----- sv/crb_timer.sv -----
// Deadline evaluation: picks the deadline base and duration for a state and
// returns the time left, floored at zero and saturating. Depends on crb_pkg.
`default_nettype none

module crb_timer #(
    parameter int TIME_BITS     = 48,
    parameter int INTERVAL_BITS = 24
) (
    input  crb_pkg::state_t           state,
    input  wire [TIME_BITS-1:0]       now,
    input  wire [TIME_BITS-1:0]       entered,
    input  wire [TIME_BITS-1:0]       last_act,
    input  wire [INTERVAL_BITS-1:0]   backoff,
    input  wire [INTERVAL_BITS-1:0]   probe,
    output logic                      dl_valid,
    output logic [INTERVAL_BITS-1:0]  left
);

    localparam logic [INTERVAL_BITS-1:0] FLOOR = INTERVAL_BITS'(crb_pkg::FLOOR_MS);

    logic [TIME_BITS-1:0]     base;
    logic [INTERVAL_BITS-1:0] dur;
    logic [TIME_BITS:0]       diff;
    logic [TIME_BITS-1:0]     gap;
    logic [TIME_BITS-1:0]     elapsed;
    logic [INTERVAL_BITS:0]   sum;

    always_comb begin
        base     = entered;
        dur      = '0;
        dl_valid = 1'b0;
        case (state)
            crb_pkg::ST_BACKOFF: begin
                dur      = backoff;
                dl_valid = 1'b1;
            end
            crb_pkg::ST_CONNECTING: begin
                dur      = (backoff > FLOOR) ? backoff : FLOOR;
                dl_valid = 1'b1;
            end
            crb_pkg::ST_ACTIVE: begin
                base     = (last_act > entered) ? last_act : entered;
                dur      = probe;
                dl_valid = (probe != '0);
            end
            crb_pkg::ST_IDLE: begin
                dur      = probe;
                dl_valid = (probe != '0);
            end
            crb_pkg::ST_RECONNECT: begin
                dl_valid = 1'b1;
            end
            default: begin
                dl_valid = 1'b0;
            end
        endcase
    end

    assign diff    = {1'b0, now} - {1'b0, base};
    assign elapsed = diff[TIME_BITS-1:0];
    assign gap     = base - now;
    assign sum     = {1'b0, gap[INTERVAL_BITS-1:0]} + {1'b0, dur};

    always_comb begin
        left = '0;
        if (dl_valid) begin
            if (diff[TIME_BITS]) begin
                // The base lies in the future, so the gap counts toward the wait.
                if (|gap[TIME_BITS-1:INTERVAL_BITS]) begin
                    left = '1;
                end else if (sum[INTERVAL_BITS]) begin
                    left = '1;
                end else begin
                    left = sum[INTERVAL_BITS-1:0];
                end
            end else if (elapsed < {{(TIME_BITS-INTERVAL_BITS){1'b0}}, dur}) begin
                left = dur - elapsed[INTERVAL_BITS-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/crb_fsm.sv -----
// Supervisor state machine: holds the configuration and connection state,
// and applies one event or poll per step. Depends on crb_pkg and crb_timer.
`default_nettype none

module crb_fsm #(
    parameter int TIME_BITS     = 48,
    parameter int INTERVAL_BITS = 24
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire [crb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [crb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                step,
    input  wire [crb_pkg::MODE_W-1:0]          mode,
    input  wire [TIME_BITS-1:0]                now,
    output crb_pkg::action_t                   action,
    output crb_pkg::status_t                   status,
    output logic [TIME_BITS-1:0]               entered,
    output logic [TIME_BITS-1:0]               last_act,
    output logic [INTERVAL_BITS-1:0]           backoff,
    output logic [INTERVAL_BITS-1:0]           probe
);

    localparam int TW = TIME_BITS;
    localparam int IW = INTERVAL_BITS;
    localparam int CW = crb_pkg::CNT_W;
    localparam logic [IW-1:0] FLOOR   = IW'(crb_pkg::FLOOR_MS);
    localparam logic [IW-1:0] DEF_MAX = IW'(crb_pkg::DEFAULT_MAX_MS);

    // Configuration registers.
    logic [IW-1:0] min_reg, min_next;
    logic [IW-1:0] max_reg, max_next;
    logic [IW-1:0] probe_reg, probe_next;
    logic          passive_reg, passive_next;

    // Connection state.
    crb_pkg::state_t st_reg, st_next;
    logic [TW-1:0]   ent_reg, ent_next;
    logic [IW-1:0]   bo_reg, bo_next;
    logic [TW-1:0]   la_reg, la_next;
    logic [TW-1:0]   lc_reg, lc_next;
    logic [CW-1:0]   tl_reg, tl_next;
    logic [CW-1:0]   ftl_reg, ftl_next;
    crb_pkg::cnt_t   cnt_reg, cnt_next;

    crb_pkg::action_t act_c;
    logic             dl_valid;
    logic [IW-1:0]    dl_left;
    logic             due;

    function automatic crb_pkg::cnt_t go_cnt(crb_pkg::cnt_t c, crb_pkg::state_t from,
                                             crb_pkg::state_t to);
        crb_pkg::cnt_t r;
        r = c;
        if (from == crb_pkg::ST_CONNECTING) begin
            r.attempts = c.attempts + 1'b1;
            if (to == crb_pkg::ST_ACTIVE) begin
                r.successes = c.successes + 1'b1;
            end
        end
        if (crb_pkg::is_linked(from) != crb_pkg::is_linked(to)) begin
            r.change_seq = c.change_seq + 1'b1;
        end
        return r;
    endfunction

    crb_timer #(
        .TIME_BITS    (TIME_BITS),
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_due (
        .state   (st_reg),
        .now     (now),
        .entered (ent_reg),
        .last_act(la_reg),
        .backoff (bo_reg),
        .probe   (probe_reg),
        .dl_valid(dl_valid),
        .left    (dl_left)
    );

    // A deadline is due exactly when one exists and no time is left.
    assign due = dl_valid && (dl_left == '0);

    always_comb begin
        crb_pkg::state_t st;
        logic [TW-1:0]   ent;
        logic [IW-1:0]   bo;
        logic [TW-1:0]   la;
        logic [TW-1:0]   lc;
        logic [CW-1:0]   tl;
        logic [CW-1:0]   ftl;
        crb_pkg::cnt_t   cnt;
        logic            do_lost;
        logic            was_linked;
        logic            fresh;
        logic [IW-1:0]   sat;
        logic [IW-1:0]   v;

        st      = st_reg;
        ent     = ent_reg;
        bo      = bo_reg;
        la      = la_reg;
        lc      = lc_reg;
        tl      = tl_reg;
        ftl     = ftl_reg;
        cnt     = cnt_reg;
        do_lost = 1'b0;
        act_c   = crb_pkg::AC_NONE;
        was_linked = 1'b0;
        fresh   = 1'b0;
        sat     = (|cfg_wdata[crb_pkg::CFG_DATA_W-1:IW]) ? '1 : cfg_wdata[IW-1:0];
        v       = sat;

        min_next     = min_reg;
        max_next     = max_reg;
        probe_next   = probe_reg;
        passive_next = passive_reg;

        if (step) begin
            case (crb_pkg::mode_t'(mode))
                crb_pkg::MD_POLL: begin
                    if (due) begin
                        case (st)
                            crb_pkg::ST_BACKOFF: begin
                                act_c = crb_pkg::AC_CONNECT;
                            end
                            crb_pkg::ST_CONNECTING, crb_pkg::ST_IDLE,
                            crb_pkg::ST_RECONNECT: begin
                                act_c = crb_pkg::AC_DISCONNECT;
                            end
                            crb_pkg::ST_ACTIVE: begin
                                cnt   = go_cnt(cnt, st, crb_pkg::ST_IDLE);
                                st    = crb_pkg::ST_IDLE;
                                ent   = now;
                                act_c = crb_pkg::AC_PROBE;
                            end
                            default: begin
                                act_c = crb_pkg::AC_NONE;
                            end
                        endcase
                    end
                end
                crb_pkg::MD_ENABLE: begin
                    if (st == crb_pkg::ST_VOID && tl != '0) begin
                        if (tl != crb_pkg::U32_ALL) begin
                            tl = tl - 1'b1;
                        end
                        cnt = go_cnt(cnt, st, crb_pkg::ST_BACKOFF);
                        st  = crb_pkg::ST_BACKOFF;
                        ent = now;
                        bo  = '0;
                    end
                end
                crb_pkg::MD_DISABLE: begin
                    if (st != crb_pkg::ST_VOID) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_VOID);
                        st  = crb_pkg::ST_VOID;
                        ent = now;
                    end
                end
                crb_pkg::MD_FORCE: begin
                    if (st == crb_pkg::ST_CONNECTING || crb_pkg::is_linked(st)) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_RECONNECT);
                        st  = crb_pkg::ST_RECONNECT;
                        ent = now;
                    end
                end
                crb_pkg::MD_DROPPED: begin
                    do_lost = 1'b1;
                end
                crb_pkg::MD_CONNECTING: begin
                    if (st != crb_pkg::ST_CONNECTING) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_CONNECTING);
                        st  = crb_pkg::ST_CONNECTING;
                        ent = now;
                    end
                end
                crb_pkg::MD_LISTENING: begin
                    if (st != crb_pkg::ST_LISTENING) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_LISTENING);
                        st  = crb_pkg::ST_LISTENING;
                        ent = now;
                    end
                end
                crb_pkg::MD_LISTEN_ERR: begin
                    do_lost = (st == crb_pkg::ST_LISTENING);
                end
                crb_pkg::MD_CONNECTED: begin
                    if (!crb_pkg::is_linked(st)) begin
                        if (st != crb_pkg::ST_CONNECTING) begin
                            cnt = go_cnt(cnt, st, crb_pkg::ST_CONNECTING);
                            st  = crb_pkg::ST_CONNECTING;
                        end
                        cnt = go_cnt(cnt, st, crb_pkg::ST_ACTIVE);
                        st  = crb_pkg::ST_ACTIVE;
                        ent = now;
                        lc  = now;
                    end
                end
                crb_pkg::MD_FAILED: begin
                    if (st != crb_pkg::ST_CONNECTING) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_CONNECTING);
                        st  = crb_pkg::ST_CONNECTING;
                        ent = now;
                    end
                    do_lost = 1'b1;
                end
                crb_pkg::MD_ACTIVITY: begin
                    if (st != crb_pkg::ST_ACTIVE) begin
                        cnt = go_cnt(cnt, st, crb_pkg::ST_ACTIVE);
                        st  = crb_pkg::ST_ACTIVE;
                        ent = now;
                    end
                    la = now;
                end
                default: begin
                    do_lost = 1'b0;
                end
            endcase

            // Loss of the link: retry budget, then the next backoff interval.
            if (do_lost && st != crb_pkg::ST_BACKOFF && st != crb_pkg::ST_VOID) begin
                was_linked = crb_pkg::is_linked(st);
                if (tl == '0) begin
                    cnt = go_cnt(cnt, st, crb_pkg::ST_VOID);
                    st  = crb_pkg::ST_VOID;
                    ent = now;
                end else begin
                    if (tl != crb_pkg::U32_ALL) begin
                        tl = tl - 1'b1;
                    end
                    fresh = was_linked && (passive_reg ||
                            (lc != '1 && la >= lc &&
                             (la - lc) >= {{(TW-IW){1'b0}}, bo}));
                    if (ftl > {{(CW-1){1'b0}}, 1'b1}) begin
                        ftl = ftl - 1'b1;
                        bo  = '0;
                    end else if (fresh) begin
                        bo = passive_reg ? '0 : min_reg;
                    end else if (bo < min_reg) begin
                        bo = min_reg;
                    end else if (bo < (max_reg >> 1)) begin
                        bo = {bo[IW-2:0], 1'b0};
                    end else begin
                        bo = max_reg;
                    end
                    cnt = go_cnt(cnt, st, crb_pkg::ST_BACKOFF);
                    st  = crb_pkg::ST_BACKOFF;
                    ent = now;
                end
            end
        end

        if (cfg_we) begin
            case (crb_pkg::cfg_idx_t'(cfg_addr))
                crb_pkg::CFG_MIN_BACKOFF: begin
                    min_next = (sat < FLOOR) ? FLOOR : sat;
                    max_next = (max_reg < min_next) ? min_next : max_reg;
                    if (st == crb_pkg::ST_BACKOFF && bo > max_next) begin
                        bo = max_next;
                    end
                end
                crb_pkg::CFG_MAX_BACKOFF: begin
                    if (v == '0) begin
                        v = DEF_MAX;
                    end
                    if (v < FLOOR) begin
                        v = FLOOR;
                    end
                    if (v < min_reg) begin
                        v = min_reg;
                    end
                    max_next = v;
                    if (st == crb_pkg::ST_BACKOFF && bo > max_next) begin
                        bo = max_next;
                    end
                end
                crb_pkg::CFG_PROBE: begin
                    probe_next = (sat != '0 && sat < FLOOR) ? FLOOR : sat;
                end
                crb_pkg::CFG_PASSIVE: begin
                    passive_next = cfg_wdata[0];
                end
                crb_pkg::CFG_TRY_LIMIT: begin
                    tl = cfg_wdata;
                end
                crb_pkg::CFG_FREE_TRIES: begin
                    ftl = cfg_wdata;
                end
                default: begin
                    passive_next = passive_reg;
                end
            endcase
        end

        st_next  = st;
        ent_next = ent;
        bo_next  = bo;
        la_next  = la;
        lc_next  = lc;
        tl_next  = tl;
        ftl_next = ftl;
        cnt_next = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= FLOOR;
            max_reg     <= DEF_MAX;
            probe_reg   <= IW'(crb_pkg::PROBE_RESET_MS);
            passive_reg <= 1'b0;
            st_reg      <= crb_pkg::ST_VOID;
            ent_reg     <= '0;
            bo_reg      <= '0;
            la_reg      <= '0;
            lc_reg      <= '1;
            tl_reg      <= crb_pkg::U32_ALL;
            ftl_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            min_reg     <= min_next;
            max_reg     <= max_next;
            probe_reg   <= probe_next;
            passive_reg <= passive_next;
            st_reg      <= st_next;
            ent_reg     <= ent_next;
            bo_reg      <= bo_next;
            la_reg      <= la_next;
            lc_reg      <= lc_next;
            tl_reg      <= tl_next;
            ftl_reg     <= ftl_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign action            = act_c;
    assign status.state      = st_reg;
    assign status.tries_left = tl_reg;
    assign status.cnt        = cnt_reg;
    assign entered           = ent_reg;
    assign last_act          = la_reg;
    assign backoff           = bo_reg;
    assign probe             = probe_reg;

endmodule

`default_nettype wire

// ----- sv/connection_retry_backoff_fsm_top.sv -----
// Top level of the connection retry/backoff supervisor: input register,
// state machine stage and result register. Depends on crb_pkg, crb_fsm, crb_timer.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_mode, s_now_ms
//   m_       out        m_valid/m_ready    m_action .. m_link_change_seq
//   cfg_     in         cfg_we (no wait)   cfg_addr, cfg_wdata
//
// A word passes three register stages: the input register, the state machine
// step (state registers plus a small register for the action and time), and the
// result register. One word is taken every cycle while m_ready does not stall the output.
// Reset is synchronous on aresetn low and clears every control and state register.
// A stalled m_ready holds the result register; the stages behind it keep filling
// until each holds a word, and only then is s_ready dropped.
`default_nettype none

module connection_retry_backoff_fsm_top #(
    parameter int TIME_BITS     = 48,
    parameter int INTERVAL_BITS = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Configuration write port.
    input  wire                              cfg_we,
    input  wire [crb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [crb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Event and poll input.
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [crb_pkg::MODE_W-1:0]        s_mode,
    input  wire [TIME_BITS-1:0]              s_now_ms,
    // Result output.
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_action,
    output logic [2:0]                       m_state_code,
    output logic                             m_is_connected,
    output logic                             m_timeout_valid,
    output logic [INTERVAL_BITS-1:0]         m_timeout_ms,
    output logic [INTERVAL_BITS-1:0]         m_backoff_now_ms,
    output logic [crb_pkg::CNT_W-1:0]        m_tries_remaining,
    output logic [crb_pkg::CNT_W-1:0]        m_attempts_total,
    output logic [crb_pkg::CNT_W-1:0]        m_successes_total,
    output logic [crb_pkg::CNT_W-1:0]        m_link_change_seq
);

    // Stage handshake. Each stage moves when it holds a word and the stage
    // ahead is empty or moving in the same cycle.
    logic out_adv;
    logic step;

    // Input register.
    logic                        in_vld_reg;
    logic [crb_pkg::MODE_W-1:0]  mode_reg;
    logic [TIME_BITS-1:0]        now_reg;

    // Step register: the state machine itself holds the post-step state, so
    // only the action and the time stamp travel with the word.
    logic                        snap_vld_reg;
    crb_pkg::action_t            snap_action_reg;
    logic [TIME_BITS-1:0]        snap_now_reg;

    // Result register.
    logic                        out_vld_reg;
    logic [1:0]                  action_reg;
    logic [2:0]                  state_reg;
    logic                        linked_reg;
    logic                        tvalid_reg;
    logic [INTERVAL_BITS-1:0]    tleft_reg;
    logic [INTERVAL_BITS-1:0]    backoff_reg;
    logic [crb_pkg::CNT_W-1:0]   tries_reg;
    logic [crb_pkg::CNT_W-1:0]   attempts_reg;
    logic [crb_pkg::CNT_W-1:0]   successes_reg;
    logic [crb_pkg::CNT_W-1:0]   seq_reg;

    crb_pkg::action_t            step_action;
    crb_pkg::status_t            status;
    logic [TIME_BITS-1:0]        entered;
    logic [TIME_BITS-1:0]        last_act;
    logic [INTERVAL_BITS-1:0]    backoff;
    logic [INTERVAL_BITS-1:0]    probe;
    logic                        dl_valid;
    logic [INTERVAL_BITS-1:0]    dl_left;

    assign out_adv = snap_vld_reg && (!out_vld_reg || m_ready);
    assign step    = in_vld_reg && (!snap_vld_reg || out_adv);
    assign s_ready = !in_vld_reg || step;

    crb_fsm #(
        .TIME_BITS    (TIME_BITS),
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .step     (step),
        .mode     (mode_reg),
        .now      (now_reg),
        .action   (step_action),
        .status   (status),
        .entered  (entered),
        .last_act (last_act),
        .backoff  (backoff),
        .probe    (probe)
    );

    // The state registers hold the state left by the word in the step register, because
    // the step stage cannot advance while that word waits; a cfg write can still change them.
    crb_timer #(
        .TIME_BITS    (TIME_BITS),
        .INTERVAL_BITS(INTERVAL_BITS)
    ) u_timer (
        .state   (status.state),
        .now     (snap_now_reg),
        .entered (entered),
        .last_act(last_act),
        .backoff (backoff),
        .probe   (probe),
        .dl_valid(dl_valid),
        .left    (dl_left)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            snap_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (!snap_vld_reg || out_adv) begin
                snap_vld_reg <= step;
            end
            if (!out_vld_reg || m_ready) begin
                out_vld_reg <= out_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mode_reg <= s_mode;
            now_reg  <= s_now_ms;
        end
        if (step) begin
            snap_action_reg <= step_action;
            snap_now_reg    <= now_reg;
        end
        if (out_adv) begin
            action_reg    <= snap_action_reg;
            state_reg     <= status.state;
            linked_reg    <= crb_pkg::is_linked(status.state);
            tvalid_reg    <= dl_valid;
            tleft_reg     <= dl_left;
            backoff_reg   <= backoff;
            tries_reg     <= status.tries_left;
            attempts_reg  <= status.cnt.attempts;
            successes_reg <= status.cnt.successes;
            seq_reg       <= status.cnt.change_seq;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_action          = action_reg;
    assign m_state_code      = state_reg;
    assign m_is_connected    = linked_reg;
    assign m_timeout_valid   = tvalid_reg;
    assign m_timeout_ms      = tleft_reg;
    assign m_backoff_now_ms  = backoff_reg;
    assign m_tries_remaining = tries_reg;
    assign m_attempts_total  = attempts_reg;
    assign m_successes_total = successes_reg;
    assign m_link_change_seq = seq_reg;

endmodule

`default_nettype wire
